// ===== design/mscc_pkg.sv =====
// Package for the MPEG-2 start code and caption parser.
// Holds the parse mode type, result codes, start code constants and the result layout.
// No dependencies.
package mscc_pkg;

    typedef enum logic [1:0]
    {
        MODE_SEARCH,
        MODE_PIC,
        MODE_USER,
        MODE_CC
    } mode_t;

    localparam logic [1:0] KIND_PIC    = 2'd0;
    localparam logic [1:0] KIND_CC     = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_NO_USER   = 3'd1;
    localparam logic [2:0] STATUS_BAD_HDR   = 3'd2;
    localparam logic [2:0] STATUS_OVER      = 3'd3;
    localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

    localparam logic [23:0] WIN_ONES     = 24'hFFFFFF;
    localparam logic [23:0] START_PREFIX = 24'h000001;

    localparam logic [7:0] CODE_PICTURE = 8'h00;
    localparam logic [7:0] CODE_SLICE   = 8'h01;
    localparam logic [7:0] CODE_USER    = 8'hB2;

    localparam logic [7:0] LIMIT_RESET = 8'd93;

    localparam logic [2:0] HDR_COUNT = 3'd5;
    localparam logic [2:0] HDR_SKIP  = 3'd6;

    typedef struct packed
    {
        logic [1:0] kind;
        logic [1:0] picture_type;
        logic [9:0] temporal_ref;
        logic [7:0] cc_byte;
        logic       cc_last;
        logic [2:0] cc_status;
        logic [6:0] cc_length;
        logic       picture_found;
        logic       slice_found;
    } res_small_t;

    // Expected user data header: "GA94" followed by the caption data type 3.
    function automatic logic [7:0] ga94_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h47;
            3'd1:    val = 8'h41;
            3'd2:    val = 8'h39;
            3'd3:    val = 8'h34;
            3'd4:    val = 8'h03;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ===== design/mscc_if.sv =====
// Channel interfaces for the MPEG-2 start code and caption parser.
// Depends on nothing; widths of the offsets follow the OW parameter.
interface mscc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface mscc_res_if #(parameter int OW = 20);
    logic          valid;
    logic          ready;
    logic [1:0]    kind;
    logic [1:0]    picture_type;
    logic [9:0]    temporal_ref;
    logic [7:0]    cc_byte;
    logic          cc_last;
    logic [2:0]    cc_status;
    logic [6:0]    cc_length;
    logic [OW-1:0] user_data_offset;
    logic          picture_found;
    logic          slice_found;
    logic [OW-1:0] insert_offset;

    modport source (output valid, output kind, output picture_type, output temporal_ref,
        output cc_byte, output cc_last, output cc_status, output cc_length,
        output user_data_offset, output picture_found, output slice_found,
        output insert_offset, input ready);
    modport sink (input valid, input kind, input picture_type, input temporal_ref,
        input cc_byte, input cc_last, input cc_status, input cc_length,
        input user_data_offset, input picture_found, input slice_found,
        input insert_offset, output ready);
endinterface

interface mscc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] cc_byte_limit;

    modport source (output valid, output cc_byte_limit, input ready);
    modport sink (input valid, input cc_byte_limit, output ready);
endinterface

// ===== design/mscc_fifo.sv =====
// Four-entry result queue that takes up to two entries and gives one per cycle.
// Generic in width; no package dependency.
module mscc_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [1:0]   push_cnt,
    input  logic [W-1:0] push_d0,
    input  logic [W-1:0] push_d1,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         not_empty,
    output logic         room2
);
    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic [PW-1:0] wptr_plus1;

    assign wptr_plus1 = wptr_reg + PW'(1);
    assign head       = mem_reg[rptr_reg];
    assign not_empty  = (cnt_reg != '0);
    assign room2      = (cnt_reg <= (PW+1)'(DEPTH - 2));

    always_comb
    begin
        wptr_next = wptr_reg + PW'(push_cnt);
        rptr_next = rptr_reg + PW'(pop);
        cnt_next  = cnt_reg + (PW+1)'(push_cnt) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wptr_reg] <= push_d0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wptr_plus1] <= push_d1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end
endmodule

// ===== design/mscc_parse.sv =====
// Byte-at-a-time start code scanner, picture header reader and caption extractor.
// Uses mscc_pkg; produces up to two packed results per accepted byte.
module mscc_parse #(
    parameter int OW = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [7:0]                            data_byte,
    input  logic                                  frame_end,
    input  logic [7:0]                            limit,
    output logic [1:0]                            push_cnt,
    output logic [$bits(mscc_pkg::res_small_t)+2*OW-1:0] push_d0,
    output logic [$bits(mscc_pkg::res_small_t)+2*OW-1:0] push_d1
);
    localparam int EW = $bits(mscc_pkg::res_small_t) + 2 * OW;

    logic [23:0]         win_reg, win_next;
    logic [OW-1:0]       pos_reg, pos_next;
    mscc_pkg::mode_t     mode_reg, mode_next;
    logic [2:0]          hidx_reg, hidx_next;
    logic [6:0]          rem_reg, rem_next;
    logic [7:0]          fhb_reg, fhb_next;
    logic [2:0]          flags_reg, flags_next;
    logic [OW-1:0]       uofs_reg, uofs_next;
    logic [OW-1:0]       sofs_reg, sofs_next;
    logic [2:0]          status_reg, status_next;
    logic [6:0]          total_reg, total_next;

    mscc_pkg::res_small_t res_a, res_b;
    logic                 a_valid;
    logic [6:0]           len;
    logic [2:0]           ct;
    logic [EW-1:0]        ent_a, ent_b;

    assign len = {2'b00, data_byte[4:0]} + {1'b0, data_byte[4:0], 1'b0};
    assign ct  = data_byte[5:3];

    always_comb
    begin
        win_next    = win_reg;
        pos_next    = pos_reg;
        mode_next   = mode_reg;
        hidx_next   = hidx_reg;
        rem_next    = rem_reg;
        fhb_next    = fhb_reg;
        flags_next  = flags_reg;
        uofs_next   = uofs_reg;
        sofs_next   = sofs_reg;
        status_next = status_reg;
        total_next  = total_reg;
        res_a       = '0;
        res_b       = '0;
        a_valid     = 1'b0;

        unique case (mode_reg)
            mscc_pkg::MODE_PIC:
            begin
                if (hidx_reg == 3'd0)
                begin
                    fhb_next  = data_byte;
                    hidx_next = 3'd1;
                end
                else
                begin
                    a_valid            = 1'b1;
                    res_a.kind         = mscc_pkg::KIND_PIC;
                    res_a.picture_type = (!ct[2] && ct != 3'd0) ? ct[1:0] : 2'd0;
                    res_a.temporal_ref = {fhb_reg, data_byte[7:6]};
                    flags_next[0]      = 1'b1;
                    mode_next          = mscc_pkg::MODE_SEARCH;
                end
            end
            mscc_pkg::MODE_USER:
            begin
                if (hidx_reg < mscc_pkg::HDR_COUNT)
                begin
                    if (data_byte != mscc_pkg::ga94_byte(hidx_reg))
                    begin
                        status_next = mscc_pkg::STATUS_BAD_HDR;
                        mode_next   = mscc_pkg::MODE_SEARCH;
                    end
                    else
                    begin
                        hidx_next = hidx_reg + 3'd1;
                    end
                end
                else if (hidx_reg == mscc_pkg::HDR_COUNT)
                begin
                    total_next = len;
                    if ({1'b0, len} > limit)
                    begin
                        status_next = mscc_pkg::STATUS_OVER;
                        mode_next   = mscc_pkg::MODE_SEARCH;
                    end
                    else if (len == 7'd0)
                    begin
                        status_next = mscc_pkg::STATUS_OK;
                        mode_next   = mscc_pkg::MODE_SEARCH;
                    end
                    else
                    begin
                        rem_next  = len;
                        hidx_next = mscc_pkg::HDR_SKIP;
                    end
                end
                else
                begin
                    mode_next = mscc_pkg::MODE_CC;
                end
            end
            mscc_pkg::MODE_CC:
            begin
                rem_next      = rem_reg - 7'd1;
                a_valid       = 1'b1;
                res_a.kind    = mscc_pkg::KIND_CC;
                res_a.cc_byte = data_byte;
                res_a.cc_last = (rem_next == 7'd0);
                if (rem_next == 7'd0)
                begin
                    status_next = mscc_pkg::STATUS_OK;
                    mode_next   = mscc_pkg::MODE_SEARCH;
                end
            end
            default:
            begin
            end
        endcase

        if (win_reg == mscc_pkg::START_PREFIX)
        begin
            if (!frame_end)
            begin
                priority if (data_byte == mscc_pkg::CODE_PICTURE
                    && mode_next == mscc_pkg::MODE_SEARCH && !flags_next[0])
                begin
                    mode_next = mscc_pkg::MODE_PIC;
                    hidx_next = 3'd0;
                end
                else if (data_byte == mscc_pkg::CODE_USER
                    && mode_next == mscc_pkg::MODE_SEARCH && !flags_next[1])
                begin
                    flags_next[1] = 1'b1;
                    uofs_next     = pos_reg + OW'(1);
                    mode_next     = mscc_pkg::MODE_USER;
                    hidx_next     = 3'd0;
                end
                else if (data_byte == mscc_pkg::CODE_SLICE && !flags_next[2])
                begin
                    flags_next[2] = 1'b1;
                    sofs_next     = pos_reg - OW'(3);
                end
                else
                begin
                end
            end
            win_next = mscc_pkg::WIN_ONES;
        end
        else
        begin
            win_next = {win_reg[15:0], data_byte};
        end

        pos_next = pos_reg + OW'(1);

        if (frame_end)
        begin
            if (mode_next == mscc_pkg::MODE_USER || mode_next == mscc_pkg::MODE_CC)
            begin
                status_next = mscc_pkg::STATUS_TRUNCATED;
            end
            res_b.kind          = mscc_pkg::KIND_STATUS;
            res_b.cc_status     = status_next;
            res_b.cc_length     = total_next;
            res_b.picture_found = flags_next[0];
            res_b.slice_found   = flags_next[2];
            ent_b               = {res_b, uofs_next, sofs_next};
            win_next    = mscc_pkg::WIN_ONES;
            pos_next    = '0;
            mode_next   = mscc_pkg::MODE_SEARCH;
            hidx_next   = 3'd0;
            rem_next    = 7'd0;
            fhb_next    = 8'd0;
            flags_next  = 3'd0;
            uofs_next   = '0;
            sofs_next   = '0;
            status_next = mscc_pkg::STATUS_NO_USER;
            total_next  = 7'd0;
        end
        else
        begin
            ent_b = '0;
        end
    end

    assign ent_a = {res_a, {(2*OW){1'b0}}};

    always_comb
    begin
        push_cnt = 2'd0;
        push_d0  = ent_a;
        push_d1  = ent_b;
        if (accept)
        begin
            push_cnt = {1'b0, a_valid} + {1'b0, frame_end};
            if (!a_valid)
            begin
                push_d0 = ent_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= mscc_pkg::WIN_ONES;
            pos_reg    <= '0;
            mode_reg   <= mscc_pkg::MODE_SEARCH;
            hidx_reg   <= 3'd0;
            rem_reg    <= 7'd0;
            fhb_reg    <= 8'd0;
            flags_reg  <= 3'd0;
            uofs_reg   <= '0;
            sofs_reg   <= '0;
            status_reg <= mscc_pkg::STATUS_NO_USER;
            total_reg  <= 7'd0;
        end
        else if (accept)
        begin
            win_reg    <= win_next;
            pos_reg    <= pos_next;
            mode_reg   <= mode_next;
            hidx_reg   <= hidx_next;
            rem_reg    <= rem_next;
            fhb_reg    <= fhb_next;
            flags_reg  <= flags_next;
            uofs_reg   <= uofs_next;
            sofs_reg   <= sofs_next;
            status_reg <= status_next;
            total_reg  <= total_next;
        end
    end
endmodule

// ===== design/mpeg2_start_code_cc_parser.sv =====
// Top level of the MPEG-2 start code scanner with GA94 caption extraction.
// Uses mscc_pkg, the channel interfaces, mscc_parse and mscc_fifo.
//
// The block takes one byte of a coded frame per cycle and parses it in the same cycle it
// is transferred, so one byte a cycle is sustained while the result queue has room. Each
// byte gives up to two results (picture info or a caption byte, then the end-of-frame
// status), which wait in a four-entry result queue; the result channel moves one a cycle,
// and the input is held off only while the queue has fewer than two free slots. A result
// appears on the output in the cycle after the byte that causes it at the earliest. The
// caption limit register is written through its own channel, which is always ready.
module mpeg2_start_code_cc_parser #(
    parameter int FRAME_OFFSET_BITS = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    mscc_in_if.sink       stream,
    mscc_cfg_if.sink      cfg,
    mscc_res_if.source    result
);
    localparam int OW = FRAME_OFFSET_BITS;
    localparam int SW = $bits(mscc_pkg::res_small_t);
    localparam int EW = SW + 2 * OW;

    logic [7:0]           limit_reg;
    logic                 accept;
    logic [1:0]           push_cnt;
    logic [EW-1:0]        push_d0, push_d1, head;
    logic                 not_empty, room2;
    mscc_pkg::res_small_t head_small;

    assign stream.ready = room2;
    assign accept       = stream.valid && room2;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= mscc_pkg::LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            limit_reg <= cfg.cc_byte_limit;
        end
    end

    mscc_parse #(
        .OW (OW)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (stream.data_byte),
        .frame_end (stream.frame_end),
        .limit     (limit_reg),
        .push_cnt  (push_cnt),
        .push_d0   (push_d0),
        .push_d1   (push_d1)
    );

    mscc_fifo #(
        .W (EW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_d0   (push_d0),
        .push_d1   (push_d1),
        .pop       (not_empty && result.ready),
        .head      (head),
        .not_empty (not_empty),
        .room2     (room2)
    );

    assign head_small              = head[EW-1 -: SW];
    assign result.valid            = not_empty;
    assign result.kind             = head_small.kind;
    assign result.picture_type     = head_small.picture_type;
    assign result.temporal_ref     = head_small.temporal_ref;
    assign result.cc_byte          = head_small.cc_byte;
    assign result.cc_last          = head_small.cc_last;
    assign result.cc_status        = head_small.cc_status;
    assign result.cc_length        = head_small.cc_length;
    assign result.picture_found    = head_small.picture_found;
    assign result.slice_found      = head_small.slice_found;
    assign result.user_data_offset = head[2*OW-1:OW];
    assign result.insert_offset    = head[OW-1:0];
endmodule

// ===== design/mscc_checker.sv =====
// Port-level checks for the MPEG-2 start code and caption parser, bound to the top level.
// Uses mscc_pkg for the result kind and status codes.
module mscc_checker #(
    parameter int OW = 20
) (
    input logic          clk,
    input logic          rst_n,
    input logic          res_valid,
    input logic          res_ready,
    input logic [1:0]    kind,
    input logic [7:0]    cc_byte,
    input logic [9:0]    temporal_ref,
    input logic [2:0]    cc_status,
    input logic [OW-1:0] user_data_offset,
    input logic [OW-1:0] insert_offset
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(cc_byte)
            && $stable(cc_status))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> kind == mscc_pkg::KIND_PIC || kind == mscc_pkg::KIND_CC
            || kind == mscc_pkg::KIND_STATUS)
        else $error("result kind out of range");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == mscc_pkg::KIND_STATUS |-> cc_status <= mscc_pkg::STATUS_TRUNCATED)
        else $error("status code out of range");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != mscc_pkg::KIND_STATUS |-> cc_status == mscc_pkg::STATUS_OK
            && user_data_offset == '0 && insert_offset == '0)
        else $error("status fields set on a non-status result");

    a_cross: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == mscc_pkg::KIND_CC |-> temporal_ref == 10'd0)
        else $error("picture field set on a caption byte");
endmodule

bind mpeg2_start_code_cc_parser mscc_checker #(
    .OW (FRAME_OFFSET_BITS)
) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .kind             (result.kind),
    .cc_byte          (result.cc_byte),
    .temporal_ref     (result.temporal_ref),
    .cc_status        (result.cc_status),
    .user_data_offset (result.user_data_offset),
    .insert_offset    (result.insert_offset)
);
